@@ src/drt_pkg.sv @@
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants for the damage rectangle tracker
// Holds command codes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int MaxDamageDefault  = 16;
  localparam int MaxResultsDefault = 16;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_EMIT  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_ADDFIN,
    ST_EMIT,
    ST_OUT,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture the input transaction
    logic clr_idx;    // reset scan index
    logic step;       // process registered entry, advance index
    logic add_fin;    // finish an add (append or overflow)
    logic emit_whole; // build the whole-surface blit
    logic emit_entry; // build a blit from registered entry
    logic out_load;   // take candidate as pending blit, send the older one
    logic out_none;   // send final result: pending blit or empty
    logic do_clear;
    logic do_mark;
  } dp_ctrl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic add_ok;     // clipped add rect nonempty and not overflowed
    logic more;       // scan index still below count
    logic found;      // add resolved (contained or replaced)
    logic cand_ok;    // candidate blit nonempty
    logic full_out;   // result budget spent
    logic use_list;   // emit walks the list
    logic no_surf;
  } dp_stat_t;

endpackage

@@ src/damage_rect_tracker_core.sv @@
// ----------------------------------------------------------------------------
// damage_rect_tracker_core: bounded damage rectangle list for one surface
// Clear, mark, rejected add and emit with no surface go from the read
// state straight to the final result; an add scans entry by entry and ends
// early at a containing or covered entry; emit builds the whole-surface blit
// or walks the list. One transaction at a time: the next input is taken in
// the cycle after the final result is loaded. Reset: synchronous.
// ----------------------------------------------------------------------------
module damage_rect_tracker_core #(
  parameter int MaxDamage = drt_pkg::MaxDamageDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] rect_x, rect_y, rect_w, rect_h,
  input  logic [15:0] place_x, place_y, clip_x, clip_y, clip_w, clip_h,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        blit_valid,
  output logic [16:0] dest_x, dest_y,
  output logic [15:0] src_x, src_y, blit_w, blit_h,
  output logic        dirty,
  output logic        last
);
  drt_pkg::dp_ctrl_t ctrl;
  drt_pkg::dp_stat_t stat;

  drt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .ctrl(ctrl)
  );

  drt_dp #(.MaxDamage(MaxDamage), .MaxResults(drt_pkg::MaxResultsDefault)) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_sel_ok(1'b1), .cfg_data(cfg_data),
    .in_cmd(cmd), .in_rx(rect_x), .in_ry(rect_y), .in_rw(rect_w), .in_rh(rect_h),
    .in_px(place_x), .in_py(place_y), .in_cx(clip_x), .in_cy(clip_y),
    .in_cw(clip_w), .in_ch(clip_h),
    .out_stall(out_stall), .out_valid(out_valid), .blit_valid(blit_valid),
    .dest_x(dest_x), .dest_y(dest_y), .src_x(src_x), .src_y(src_y),
    .blit_w(blit_w), .blit_h(blit_h), .dirty(dirty), .last(last)
  );
endmodule

@@ src/drt_ram.sv @@
// ----------------------------------------------------------------------------
// drt_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module drt_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/drt_ctrl.sv @@
// ----------------------------------------------------------------------------
// drt_ctrl: command sequencer for the damage rectangle tracker
// Steps the datapath through add scans and emit walks, drives handshakes.
// ----------------------------------------------------------------------------
module drt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_valid,
  input  logic              out_stall,
  input  drt_pkg::dp_stat_t stat,
  output drt_pkg::dp_ctrl_t ctrl
);
  drt_pkg::state_t state, state_next;
  logic out_take;
  logic acc;

  assign acc      = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      drt_pkg::ST_IDLE: if (acc) state_next = drt_pkg::ST_READ;
      drt_pkg::ST_READ: begin
        case (stat.cmd)
          drt_pkg::CMD_ADD:
            state_next = stat.add_ok ? drt_pkg::ST_SCAN : drt_pkg::ST_DONE;
          drt_pkg::CMD_EMIT: begin
            if (stat.no_surf) state_next = drt_pkg::ST_DONE;
            else if (stat.use_list) state_next = drt_pkg::ST_SCAN;
            else state_next = drt_pkg::ST_EMIT;
          end
          default: state_next = drt_pkg::ST_DONE;
        endcase
      end
      drt_pkg::ST_SCAN: begin
        if (stat.cmd == drt_pkg::CMD_ADD) begin
          if (!stat.more) state_next = drt_pkg::ST_ADDFIN;
          else state_next = drt_pkg::ST_EMIT;
        end else begin
          state_next = (stat.more && !stat.full_out) ? drt_pkg::ST_EMIT : drt_pkg::ST_DONE;
        end
      end
      drt_pkg::ST_EMIT: begin
        if (stat.cmd == drt_pkg::CMD_ADD) begin
          state_next = stat.found ? drt_pkg::ST_DONE : drt_pkg::ST_SCAN;
        end else begin
          state_next = drt_pkg::ST_OUT;
        end
      end
      drt_pkg::ST_OUT: begin
        if (!stat.cand_ok) begin
          state_next = stat.use_list ? drt_pkg::ST_SCAN : drt_pkg::ST_DONE;
        end else if (!out_valid || out_take) begin
          state_next = stat.use_list ? drt_pkg::ST_SCAN : drt_pkg::ST_DONE;
        end
      end
      drt_pkg::ST_ADDFIN: state_next = drt_pkg::ST_DONE;
      drt_pkg::ST_DONE: if (!out_valid || out_take) state_next = drt_pkg::ST_IDLE;
      default: state_next = drt_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctrl = '0;
    in_stall = (state != drt_pkg::ST_IDLE);
    case (state)
      drt_pkg::ST_IDLE: begin
        ctrl.latch   = acc;
        ctrl.clr_idx = acc;
      end
      drt_pkg::ST_READ: begin
        ctrl.do_clear = (stat.cmd == drt_pkg::CMD_CLEAR);
        ctrl.do_mark  = (stat.cmd == drt_pkg::CMD_MARK);
      end
      drt_pkg::ST_EMIT: begin
        if (stat.cmd == drt_pkg::CMD_ADD) ctrl.step = 1'b1;
        else if (stat.use_list) ctrl.emit_entry = 1'b1;
        else ctrl.emit_whole = 1'b1;
      end
      drt_pkg::ST_OUT: begin
        if (stat.cand_ok && (!out_valid || out_take)) ctrl.out_load = 1'b1;
        if (stat.use_list && (!stat.cand_ok || !out_valid || out_take)) ctrl.step = 1'b1;
      end
      drt_pkg::ST_ADDFIN: ctrl.add_fin = 1'b1;
      drt_pkg::ST_DONE: ctrl.out_none = (!out_valid || out_take);
      default: ;
    endcase
  end
endmodule

@@ src/drt_dp.sv @@
// ----------------------------------------------------------------------------
// drt_dp: datapath for the damage rectangle tracker
// Holds the damage list, count, overflow flag, blit arithmetic and output.
// ----------------------------------------------------------------------------
module drt_dp #(
  parameter int MaxDamage  = drt_pkg::MaxDamageDefault,
  parameter int MaxResults = drt_pkg::MaxResultsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  drt_pkg::dp_ctrl_t ctrl,
  output drt_pkg::dp_stat_t stat,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic              cfg_sel_ok,
  input  logic [15:0]       cfg_data,
  input  logic [1:0]        in_cmd,
  input  logic [15:0]       in_rx, in_ry, in_rw, in_rh,
  input  logic [15:0]       in_px, in_py, in_cx, in_cy, in_cw, in_ch,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              blit_valid,
  output logic [16:0]       dest_x, dest_y,
  output logic [15:0]       src_x, src_y, blit_w, blit_h,
  output logic              dirty,
  output logic              last
);
  localparam int AW = (MaxDamage > 1) ? $clog2(MaxDamage) : 1;
  localparam int CW = $clog2(MaxDamage + 1);
  localparam int RW = $clog2(MaxResults + 1);

  logic [15:0] sw, sh;
  drt_pkg::cmd_t cmd;
  logic [15:0] rx, ry, rw, rh, px, py, cx, cy, cw, ch;
  logic [CW-1:0] count;
  logic whole;
  logic [CW-1:0] idx;
  logic [RW-1:0] nres;
  logic [63:0] rdata;
  logic we;
  logic [AW-1:0] waddr;
  logic [63:0] wdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= '0;
      sh <= '0;
    end else if (cfg_we && cfg_sel_ok) begin
      if (!cfg_idx) sw <= cfg_data;
      else sh <= cfg_data;
    end
  end

  // clipped add rect, formed at capture
  logic        a_ok;
  logic [15:0] a_w, a_h;
  logic [16:0] sxr, syr;
  always_comb begin
    sxr = {1'b0, sw} - {1'b0, in_rx};
    syr = {1'b0, sh} - {1'b0, in_ry};
    a_ok = (in_rw != 0) && (in_rh != 0) && (in_rx < sw) && (in_ry < sh);
    a_w = ({1'b0, in_rw} > sxr) ? sxr[15:0] : in_rw;
    a_h = ({1'b0, in_rh} > syr) ? syr[15:0] : in_rh;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd <= drt_pkg::cmd_t'(in_cmd);
      rx <= in_rx; ry <= in_ry;
      rw <= (in_cmd == drt_pkg::CMD_ADD) ? a_w : in_rw;
      rh <= (in_cmd == drt_pkg::CMD_ADD) ? a_h : in_rh;
      px <= in_px; py <= in_py; cx <= in_cx; cy <= in_cy; cw <= in_cw; ch <= in_ch;
    end
  end
  logic add_ok_r;
  always_ff @(posedge clk) begin
    if (ctrl.latch) add_ok_r <= a_ok;
  end

  drt_ram #(.Width(64), .Depth(MaxDamage)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(idx[AW-1:0]), .rdata(rdata)
  );

  logic [15:0] ex, ey, ew, eh;
  assign {ex, ey, ew, eh} = rdata;

  // containment tests on the registered entry
  logic [16:0] x2, y2, ex2, ey2;
  logic in_ent, cov_ent;
  always_comb begin
    x2  = {1'b0, rx} + {1'b0, rw};
    y2  = {1'b0, ry} + {1'b0, rh};
    ex2 = {1'b0, ex} + {1'b0, ew};
    ey2 = {1'b0, ey} + {1'b0, eh};
    in_ent  = (rx >= ex) && (ry >= ey) && (x2 <= ex2) && (y2 <= ey2);
    cov_ent = (ex >= rx) && (ey >= ry) && (ex2 <= x2) && (ey2 <= y2);
  end

  // candidate blit: whole surface or one entry, then clip and surface clip
  logic [16:0] bx, by, bw, bh;
  logic [17:0] ax2, ay2, kx2, ky2, ox2, oy2;
  logic [16:0] ox, oy;
  logic clip_on, isect_ok;
  always_comb begin
    clip_on = (cw != 0) && (ch != 0);
    if (ctrl.emit_whole) begin
      bx = {1'b0, px}; by = {1'b0, py}; bw = {1'b0, sw}; bh = {1'b0, sh};
    end else begin
      bx = {1'b0, px} + {1'b0, ex}; by = {1'b0, py} + {1'b0, ey};
      bw = {1'b0, ew}; bh = {1'b0, eh};
    end
    ax2 = {1'b0, bx} + {1'b0, bw};
    ay2 = {1'b0, by} + {1'b0, bh};
    kx2 = {2'b0, cx} + {2'b0, cw};
    ky2 = {2'b0, cy} + {2'b0, ch};
    ox = (bx > {1'b0, cx}) ? bx : {1'b0, cx};
    oy = (by > {1'b0, cy}) ? by : {1'b0, cy};
    ox2 = (ax2 < kx2) ? ax2 : kx2;
    oy2 = (ay2 < ky2) ? ay2 : ky2;
    isect_ok = (bw != 0) && (bh != 0) && ({1'b0, ox} < ox2) && ({1'b0, oy} < oy2);
  end

  // stage 1 register: pre-surface-clip blit
  logic        c_ok;
  logic [16:0] c_dx, c_dy;
  logic [16:0] c_sx, c_sy;
  logic [16:0] c_w, c_h;
  always_ff @(posedge clk) begin
    if (ctrl.emit_whole || ctrl.emit_entry) begin
      if (clip_on) begin
        c_ok <= isect_ok;
        c_dx <= ox; c_dy <= oy;
        c_sx <= ox - {1'b0, px}; c_sy <= oy - {1'b0, py};
        c_w  <= ox2[16:0] - ox; c_h <= oy2[16:0] - oy;
      end else begin
        c_ok <= 1'b1;
        c_dx <= bx; c_dy <= by;
        c_sx <= ctrl.emit_whole ? 17'd0 : {1'b0, ex};
        c_sy <= ctrl.emit_whole ? 17'd0 : {1'b0, ey};
        c_w  <= bw; c_h <= bh;
      end
    end
  end

  // surface clip of candidate
  logic        f_ok;
  logic [16:0] lx, ly;
  logic [15:0] f_w, f_h;
  always_comb begin
    lx = {1'b0, sw} - c_sx;
    ly = {1'b0, sh} - c_sy;
    f_ok = c_ok && (c_w != 0) && (c_h != 0) && (c_sx < {1'b0, sw}) && (c_sy < {1'b0, sh})
           && (nres < RW'(MaxResults));
    f_w = (c_w > lx) ? lx[15:0] : c_w[15:0];
    f_h = (c_h > ly) ? ly[15:0] : c_h[15:0];
  end

  // list state and scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      whole <= 1'b0;
    end else begin
      if (ctrl.do_clear) begin
        count <= '0; whole <= 1'b0;
      end
      if (ctrl.do_mark) begin
        count <= '0; whole <= 1'b1;
      end
      if (ctrl.add_fin) begin
        if (count >= CW'(MaxDamage)) begin
          whole <= 1'b1; count <= '0;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (ctrl.clr_idx) begin
      idx <= '0; nres <= '0;
    end else begin
      if (ctrl.step) idx <= idx + 1'b1;
      if (ctrl.out_load) nres <= nres + 1'b1;
    end
  end

  // list write: replace on cover, append at finish
  always_comb begin
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = {rx, ry, rw, rh};
    if (ctrl.step && cmd == drt_pkg::CMD_ADD && !in_ent && cov_ent) we = 1'b1;
    if (ctrl.add_fin && count < CW'(MaxDamage)) begin
      we = 1'b1;
      waddr = count[AW-1:0];
    end
  end

  // status to controller
  always_comb begin
    stat.cmd      = cmd;
    stat.add_ok   = add_ok_r && !whole;
    stat.more     = idx < count;
    stat.found    = in_ent || cov_ent;
    stat.cand_ok  = f_ok;
    stat.full_out = nres >= RW'(MaxResults);
    stat.use_list = !whole && (count != 0);
    stat.no_surf  = (sw == 0) || (sh == 0);
  end

  // pending blit, held until the next blit or the end of the walk shows
  // whether it is the final one
  logic        h_ok;
  logic [16:0] h_dx, h_dy;
  logic [15:0] h_sx, h_sy, h_w, h_h;
  always_ff @(posedge clk) begin
    if (ctrl.clr_idx) begin
      h_ok <= 1'b0;
    end else if (ctrl.out_load) begin
      h_ok <= 1'b1;
      h_dx <= c_dx; h_dy <= c_dy;
      h_sx <= c_sx[15:0]; h_sy <= c_sy[15:0];
      h_w  <= f_w; h_h <= f_h;
    end
  end

  // output register
  logic out_take;
  logic send;
  assign out_take = out_valid && !out_stall;
  assign send     = (ctrl.out_load && h_ok) || ctrl.out_none;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (send) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (send) begin
      // pending blit, or empty result when nothing was produced
      blit_valid <= h_ok;
      dest_x <= h_ok ? h_dx : '0;
      dest_y <= h_ok ? h_dy : '0;
      src_x  <= h_ok ? h_sx : '0;
      src_y  <= h_ok ? h_sy : '0;
      blit_w <= h_ok ? h_w : '0;
      blit_h <= h_ok ? h_h : '0;
      dirty <= whole || (count != 0);
      last <= ctrl.out_none;
    end
  end
endmodule

@@ bench/damage_rect_tracker_core_tb.sv @@
// ----------------------------------------------------------------------------
// damage_rect_tracker_core_tb: self-checking bench for the damage list tracker
// Drives add, clear, mark and emit transactions over several surface sizes,
// checks directed rows against listed results, predicts the rest with a behavioral
// copy of the tracker, and compares each result field by field, in part under random sender and receiver stalls.
// ----------------------------------------------------------------------------
module damage_rect_tracker_core_tb;

  localparam int MaxBlits    = 16;
  localparam int ListDepth   = 16;
  localparam int SettleWait  = 80;    // longest emit walk plus margin
  localparam int DeadLimit   = 3000;  // cycles with no transaction at all
  localparam int LongHold    = 400;
  localparam int IdxWidth    = 0;     // register indexes
  localparam int IdxHeight   = 1;

  typedef struct {
    drt_pkg::cmd_t cmd;
    logic [15:0]   rx, ry, rw, rh, px, py, cx, cy, cw, ch;
  } cmd_item_t;

  typedef struct {
    logic        bv;
    logic [16:0] dx, dy;
    logic [15:0] sx, sy, w, h;
    logic        dirty;
    logic        last;
  } blit_t;

  typedef struct {
    cmd_item_t it;
    bit        typed;
    blit_t     want;
  } row_t;

  typedef struct { int unsigned x, y, w, h; } box_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_idx = 0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  cmd = '0;
  logic [15:0] rect_x = '0, rect_y = '0, rect_w = '0, rect_h = '0;
  logic [15:0] place_x = '0, place_y = '0, clip_x = '0, clip_y = '0;
  logic [15:0] clip_w = '0, clip_h = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        blit_valid;
  logic [16:0] dest_x, dest_y;
  logic [15:0] src_x, src_y, blit_w, blit_h;
  logic        dirty, last;

  damage_rect_tracker_core DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // tracker shadow state
  box_t        shadow_list[ListDepth];
  int unsigned shadow_count = 0;
  bit          shadow_overflow = 0;
  int unsigned surf_w = 0, surf_h = 0;

  blit_t       blit_q[$];
  row_t        rows[$];
  int          send_idle = 0, recv_idle = 0;
  bit          hold_req = 0;
  int          errors = 0;
  int          n_items = 0, n_results = 0, n_blits = 0, n_overflows = 0;

  // clip to the surface, false when nothing is left
  function automatic bit clip_surf(inout int unsigned x, y, w, h);
    if (w == 0 || h == 0 || x >= surf_w || y >= surf_h) return 0;
    if (w > surf_w - x) w = surf_w - x;
    if (h > surf_h - y) h = surf_h - y;
    return 1;
  endfunction

  function automatic bit overlap(input int unsigned ax, ay, aw, ah, bx, by, bw, bh,
                                 output box_t o);
    int unsigned x1, y1, x2, y2;
    o = '{0, 0, 0, 0};
    if (aw == 0 || ah == 0 || bw == 0 || bh == 0) return 0;
    x1 = (ax > bx) ? ax : bx;
    y1 = (ay > by) ? ay : by;
    x2 = (ax + aw < bx + bw) ? ax + aw : bx + bw;
    y2 = (ay + ah < by + bh) ? ay + ah : by + bh;
    if (x1 >= x2 || y1 >= y2) return 0;
    o = '{x1, y1, x2 - x1, y2 - y1};
    return 1;
  endfunction

  function automatic void push_blit(ref blit_t res[$], input int unsigned dx, dy,
                                    sx, sy, w, h);
    blit_t b;
    if (res.size() >= MaxBlits) return;
    if (!clip_surf(sx, sy, w, h)) return;
    b.bv = 1; b.dx = dx[16:0]; b.dy = dy[16:0]; b.sx = sx[15:0]; b.sy = sy[15:0];
    b.w = w[15:0]; b.h = h[15:0]; b.dirty = 0; b.last = 0;
    res.push_back(b);
  endfunction

  function automatic void add_damage(input cmd_item_t it);
    int unsigned x, y, w, h, x2, y2, rx2, ry2;
    x = it.rx; y = it.ry; w = it.rw; h = it.rh;
    if (shadow_overflow) return;
    if (!clip_surf(x, y, w, h)) return;
    x2 = x + w; y2 = y + h;
    for (int i = 0; i < shadow_count; i++) begin
      rx2 = shadow_list[i].x + shadow_list[i].w;
      ry2 = shadow_list[i].y + shadow_list[i].h;
      if (x >= shadow_list[i].x && y >= shadow_list[i].y && x2 <= rx2 && y2 <= ry2)
        return;
      if (shadow_list[i].x >= x && shadow_list[i].y >= y && rx2 <= x2 && ry2 <= y2) begin
        shadow_list[i] = '{x, y, w, h};
        return;
      end
    end
    if (shadow_count >= ListDepth) begin
      shadow_overflow = 1;
      shadow_count = 0;
      n_overflows++;
      return;
    end
    shadow_list[shadow_count] = '{x, y, w, h};
    shadow_count++;
  endfunction

  function automatic void emit_blits(input cmd_item_t it, ref blit_t res[$]);
    bit          clipping;
    box_t        o;
    int unsigned bx, by;
    clipping = (it.cw != 0) && (it.ch != 0);
    if (surf_w == 0 || surf_h == 0) return;
    if (shadow_overflow || shadow_count == 0) begin
      if (!clipping) begin
        push_blit(res, it.px, it.py, 0, 0, surf_w, surf_h);
      end else if (overlap(it.px, it.py, surf_w, surf_h, it.cx, it.cy, it.cw, it.ch, o)) begin
        push_blit(res, o.x, o.y, o.x - it.px, o.y - it.py, o.w, o.h);
      end
      return;
    end
    for (int i = 0; i < shadow_count; i++) begin
      bx = it.px + shadow_list[i].x;
      by = it.py + shadow_list[i].y;
      if (!clipping)
        push_blit(res, bx, by, shadow_list[i].x, shadow_list[i].y,
                  shadow_list[i].w, shadow_list[i].h);
      else if (overlap(bx, by, shadow_list[i].w, shadow_list[i].h,
                       it.cx, it.cy, it.cw, it.ch, o))
        push_blit(res, o.x, o.y, o.x - it.px, o.y - it.py, o.w, o.h);
    end
  endfunction

  // advance the shadow state and append the results of one transaction
  function automatic void predict_blits(input cmd_item_t it, ref blit_t q[$]);
    blit_t res[$];
    bit    now_dirty;
    case (it.cmd)
      drt_pkg::CMD_ADD:   add_damage(it);
      drt_pkg::CMD_CLEAR: begin
        shadow_count = 0;
        shadow_overflow = 0;
      end
      drt_pkg::CMD_MARK:  begin
        shadow_overflow = 1;
        shadow_count = 0;
      end
      default:   emit_blits(it, res);
    endcase
    if (res.size() == 0) res.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    now_dirty = shadow_overflow || (shadow_count != 0);
    foreach (res[k]) res[k].dirty = now_dirty;
    res[res.size() - 1].last = 1;
    foreach (res[k]) q.push_back(res[k]);
  endfunction

  task automatic add_row(input drt_pkg::cmd_t c, input int rx, ry, rw, rh, px, py, cx, cy,
                         cw, ch, input bit typed, input int bv, dx, dy, sx, sy, w, h, dt);
    row_t r;
    r.it = '{c, 16'(rx), 16'(ry), 16'(rw), 16'(rh), 16'(px), 16'(py), 16'(cx), 16'(cy),
             16'(cw), 16'(ch)};
    r.typed = typed;
    r.want = '{1'(bv), 17'(dx), 17'(dy), 16'(sx), 16'(sy), 16'(w), 16'(h), 1'(dt), 1'b1};
    rows.push_back(r);
  endtask

  task automatic send_item(input cmd_item_t it, input bit typed, input blit_t want);
    blit_t scratch[$];
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd <= it.cmd;
    rect_x <= it.rx; rect_y <= it.ry; rect_w <= it.rw; rect_h <= it.rh;
    place_x <= it.px; place_y <= it.py;
    clip_x <= it.cx; clip_y <= it.cy; clip_w <= it.cw; clip_h <= it.ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    if (typed) begin
      predict_blits(it, scratch);
      blit_q.push_back(want);
    end else begin
      predict_blits(it, blit_q);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 0;
    @(posedge clk);
    while (blit_q.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic set_surface(input int w, input int h);
    cfg_we <= 1; cfg_idx <= 1'(IdxWidth); cfg_data <= w[15:0];
    @(posedge clk);
    cfg_idx <= 1'(IdxHeight); cfg_data <= h[15:0];
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    surf_w = w;
    surf_h = h;
  endtask

  function automatic logic [15:0] pick_pos(input int unsigned lim);
    if ($urandom_range(0, 99) < 12) return 16'($urandom);
    return (lim == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, lim - 1));
  endfunction

  // mostly in-surface small rectangles so the list fills and overflows
  function automatic cmd_item_t random_item();
    cmd_item_t   it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.cmd = (r < 64) ? drt_pkg::CMD_ADD : (r < 84) ? drt_pkg::CMD_EMIT :
             (r < 92) ? drt_pkg::CMD_CLEAR : drt_pkg::CMD_MARK;
    it.rx = pick_pos(surf_w);
    it.ry = pick_pos(surf_h);
    it.rw = ($urandom_range(0, 99) < 15) ? 16'($urandom) : 16'($urandom_range(1, 9));
    it.rh = ($urandom_range(0, 99) < 15) ? 16'($urandom) : 16'($urandom_range(1, 9));
    it.px = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50));
    it.py = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50));
    it.cx = 16'($urandom);
    it.cy = 16'($urandom);
    it.cw = 16'($urandom);
    it.ch = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 40) begin
      it.cw = 0; it.ch = 0;
    end else if (r < 70) begin
      it.cx = it.px + 16'($urandom_range(0, 20));
      it.cy = it.py + 16'($urandom_range(0, 20));
      it.cw = 16'($urandom_range(1, 40));
      it.ch = 16'($urandom_range(1, 40));
    end else if (r < 78) begin
      it.cw = 0;
    end
    return it;
  endfunction

  // result checker, receiver stall and watchdog
  int recv_hold = 0;
  int dead_cycles = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (blit_valid) n_blits++;
        if (blit_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction at %0t", $time);
        end else begin
          blit_t w;
          w = blit_q.pop_front();
          if (blit_valid !== w.bv || dest_x !== w.dx || dest_y !== w.dy ||
              src_x !== w.sx || src_y !== w.sy || blit_w !== w.w || blit_h !== w.h ||
              dirty !== w.dirty || last !== w.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: exp bv=%0d d=(%0d,%0d) s=(%0d,%0d) %0dx%0d %s",
                       $time, w.bv, w.dx, w.dy, w.sx, w.sy, w.w, w.h,
                       $sformatf("dirty=%0d last=%0d", w.dirty, w.last));
              $display("  got bv=%0d d=(%0d,%0d) s=(%0d,%0d) %0dx%0d dirty=%0d last=%0d",
                       blit_valid, dest_x, dest_y, src_x, src_y, blit_w, blit_h,
                       dirty, last);
            end
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) dead_cycles <= 0;
      else dead_cycles <= dead_cycles + 1;
      if (dead_cycles >= DeadLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
      if (hold_req && recv_hold == 0) begin
        recv_hold <= LongHold;
        out_stall <= 1;
      end else if (recv_hold > 1) begin
        recv_hold <= recv_hold - 1;
        out_stall <= 1;
      end else begin
        recv_hold <= 0;
        out_stall <= ($urandom_range(0, 99) < recv_idle);
      end
    end
  end

  // stimulus
  initial begin
    blit_t     none;
    cmd_item_t it;
    none = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed walk on a 64x48 surface
    set_surface(64, 48);
    add_row(drt_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_EMIT, 0, 0, 0, 0, 10, 20, 0, 0, 0, 0, 1, 1, 10, 20, 0, 0, 64, 48, 0);
    add_row(drt_pkg::CMD_EMIT, 0, 0, 0, 0, 10, 20, 0, 0, 5, 5, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_ADD, 0, 0, 0, 5, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_ADD, 64, 0, 1, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_ADD, 0, 48, 1, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_ADD, 60, 40, 65535, 65535, 0, 0, 0, 0, 0, 0,
            1, 0, 0, 0, 0, 0, 0, 0, 1);
    add_row(drt_pkg::CMD_ADD, 61, 41, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_ADD, 0, 0, 10, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_ADD, 0, 0, 20, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_ADD, 30, 5, 4, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_EMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_EMIT, 0, 0, 0, 0, 65535, 65535, 65535, 65535, 65535, 65535,
            0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_EMIT, 0, 0, 0, 0, 100, 100, 105, 105, 30, 3,
            0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_EMIT, 0, 0, 0, 0, 7, 9, 0, 0, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_EMIT, 0, 0, 0, 0, 7, 9, 0, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_MARK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1);
    add_row(drt_pkg::CMD_ADD, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1);
    add_row(drt_pkg::CMD_EMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 64, 48, 1);
    add_row(drt_pkg::CMD_EMIT, 0, 0, 0, 0, 65535, 0, 65530, 0, 65535, 65535,
            0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(drt_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);
    drain_and_settle();

    // random phases over several surface sizes; the list carries across
    for (int ph = 0; ph < 4; ph++) begin
      int count;
      case (ph)
        0: begin set_surface(64, 48);       send_idle = 12; recv_idle = 63; count = 30; end
        1: begin set_surface(65535, 65535); send_idle = 63; recv_idle = 12; count = 30; end
        2: begin set_surface(0, 37);        send_idle = 0;  recv_idle = 0;  count = 10; end
        default: begin set_surface(13, 1);  send_idle = 0;  recv_idle = 0;  count = 20; end
      endcase
      if (ph == 1) hold_req = 1;
      for (int n = 0; n < count; n++) begin
        it = random_item();
        send_item(it, 0, none);
        if (ph == 1 && n == 20) hold_req = 0;
      end
      hold_req = 0;
      drain_and_settle();
    end

    $display("covered %0d transactions in, %0d results out (%0d blits), %0d list overflows",
             n_items, n_results, n_blits, n_overflows);
    $display("surface sizes 64x48, 65535x65535, 0x37, 13x1 with stalls on both sides");
    if (errors == 0 && blit_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, blit_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
